// ===== hw/rtl/evad_pkg.sv =====
// Shared types, codes and sizes for the energy voice activity detector.
package evad_pkg;

    // Frame geometry and derived widths
    localparam int FRAME_LEN = 320;
    localparam int CNT_W     = $clog2(FRAME_LEN + 1);
    localparam int SUM_W     = $clog2(FRAME_LEN * 32768 + 1);
    localparam int STEP_W    = $clog2(SUM_W);

    // Field widths
    localparam int THR_W  = 16;
    localparam int SIL_W  = 8;
    localparam int RATE_W = 17;
    localparam int CAP_W  = 20;
    localparam int CFG_W  = 20;
    localparam int LVL_W  = 16;

    // Request codes
    localparam logic [1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [1:0] REQ_SRC_END = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // Stop causes
    localparam logic [2:0] CAUSE_RUN       = 3'd0;
    localparam logic [2:0] CAUSE_SILENCE   = 3'd1;
    localparam logic [2:0] CAUSE_NO_SPEECH = 3'd2;
    localparam logic [2:0] CAUSE_CAPACITY  = 3'd3;
    localparam logic [2:0] CAUSE_SRC_END   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_SILENCE   = 2'd1;
    localparam logic [1:0] CFG_RATE      = 2'd2;
    localparam logic [1:0] CFG_MAX       = 2'd3;

    // Configuration reset values
    localparam logic [THR_W-1:0]  THR_RESET  = 16'd900;
    localparam logic [SIL_W-1:0]  SIL_RESET  = 8'd40;
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd16000;
    localparam logic [CAP_W-1:0]  MAX_RESET  = 20'd160000;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] sample;
        logic               frame_end;
    } req_t;

    typedef struct packed {
        logic               stored;
        logic signed [15:0] stored_sample;
        logic               frame_done;
        logic [LVL_W-1:0]   frame_level;
        logic               speech_seen;
        logic               stopped;
        logic [2:0]         stop_cause;
        logic [CAP_W-1:0]   total_samples;
        logic               too_short;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CLOSE,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/energy_voice_activity_detector_core.sv =====
// Energy voice activity detector core: frame energy, speech tracking, capture stop.
// Flow: an item that does not close a frame goes straight from idle to the output state;
// a frame-closing item first passes a 24-step shared restoring divider and one close step.
// The block takes no new item while one is in flight; the divider
// handles one item at a time and req_stall stays high until the result is registered.
// Reset (rst_n, async low) clears the session and loads the configuration defaults.
module energy_voice_activity_detector_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  evad_pkg::req_t          req_item,
    output logic                    res_valid,
    input  logic                    res_stall,
    output evad_pkg::res_t          res_item,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [evad_pkg::CFG_W-1:0] cfg_data
);

    // Control
    evad_pkg::state_t state_reg, state_next;
    logic accept;
    logic out_load;
    logic div_last;
    logic close_now;

    // Configuration
    logic [evad_pkg::THR_W-1:0]  thr_reg;
    logic [evad_pkg::SIL_W-1:0]  sil_reg;
    logic [evad_pkg::RATE_W-1:0] rate_reg;
    logic [evad_pkg::CAP_W-1:0]  max_reg;

    // Session state
    logic [evad_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [evad_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [evad_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [evad_pkg::SIL_W-1:0] quiet_reg, quiet_next;
    logic                       speech_reg, speech_next;
    logic [2:0]                 cause_reg, cause_next;

    // Pending result fields
    logic                       pstored_reg, pstored_next;
    logic signed [15:0]         psample_reg, psample_next;
    logic                       pdone_reg, pdone_next;
    logic [evad_pkg::LVL_W-1:0] plevel_reg, plevel_next;

    // Shared divider
    logic [evad_pkg::SUM_W-1:0]  dvd_reg, dvd_next;
    logic [evad_pkg::CNT_W-1:0]  dvs_reg, dvs_next;
    logic [evad_pkg::CNT_W-1:0]  rem_reg, rem_next;
    logic [evad_pkg::STEP_W-1:0] step_reg, step_next;
    logic [evad_pkg::CNT_W:0]    trial;
    logic                        trial_ge;

    // Output register
    logic           out_valid_reg, out_valid_next;
    evad_pkg::res_t out_item_reg, out_item_next;

    // Helpers
    logic [15:0]                mag;
    logic [evad_pkg::SUM_W-1:0] sum_add;
    logic [evad_pkg::CNT_W-1:0] cnt_add;
    logic [evad_pkg::CAP_W:0]   cap_plus_frame;
    logic                       over_cap;
    logic [evad_pkg::SIL_W-1:0] quiet_inc;
    logic [2:0]                 cause_close;

    assign cfg_ready = 1'b1;
    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

    // Arithmetic helpers
    assign mag     = req_item.sample[15] ? (~req_item.sample + 16'd1) : req_item.sample;
    assign sum_add = sum_reg + {{(evad_pkg::SUM_W-16){1'b0}}, mag};
    assign cnt_add = cnt_reg + evad_pkg::CNT_W'(1);
    assign cap_plus_frame = {1'b0, cap_reg} + (evad_pkg::CAP_W+1)'(evad_pkg::FRAME_LEN);
    assign over_cap = cap_plus_frame > {1'b0, max_reg};
    assign close_now = (cnt_add >= evad_pkg::CNT_W'(evad_pkg::FRAME_LEN))
                       || req_item.frame_end;
    assign quiet_inc = (quiet_reg != {evad_pkg::SIL_W{1'b1}})
                       ? quiet_reg + evad_pkg::SIL_W'(1) : quiet_reg;

    // Divider step
    assign trial    = {rem_reg, dvd_reg[evad_pkg::SUM_W-1]};
    assign trial_ge = trial >= {1'b0, dvs_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            evad_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_item.req_type == evad_pkg::REQ_SAMPLE
                        && cause_reg == evad_pkg::CAUSE_RUN
                        && !(cnt_reg == '0 && over_cap) && close_now)
                        state_next = evad_pkg::ST_DIV;
                    else
                        state_next = evad_pkg::ST_OUT;
                end
            end
            evad_pkg::ST_DIV:
            begin
                if (div_last)
                    state_next = evad_pkg::ST_CLOSE;
            end
            evad_pkg::ST_CLOSE:
                state_next = evad_pkg::ST_OUT;
            evad_pkg::ST_OUT:
            begin
                if (out_load)
                    state_next = evad_pkg::ST_IDLE;
            end
            default:
                state_next = evad_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        req_stall = 1'b1;
        out_load  = 1'b0;
        div_last  = 1'b0;
        case (state_reg)
            evad_pkg::ST_IDLE:
                req_stall = 1'b0;
            evad_pkg::ST_DIV:
                div_last = step_reg == evad_pkg::STEP_W'(evad_pkg::SUM_W - 1);
            evad_pkg::ST_CLOSE:
                req_stall = 1'b1;
            evad_pkg::ST_OUT:
                out_load = !out_valid_reg || !res_stall;
            default:
                req_stall = 1'b1;
        endcase
    end

    assign accept = req_valid && !req_stall;

    // Cause after a frame close (uses the level held in the divider)
    always_comb
    begin
        cause_close = cause_reg;
        if (dvd_reg[evad_pkg::LVL_W-1:0] <= thr_reg)
        begin
            if (speech_reg)
            begin
                if (quiet_inc >= sil_reg)
                    cause_close = evad_pkg::CAUSE_SILENCE;
            end
            else if (cap_reg > {{(evad_pkg::CAP_W-evad_pkg::RATE_W){1'b0}}, rate_reg})
                cause_close = evad_pkg::CAUSE_NO_SPEECH;
        end
        if (cause_close == evad_pkg::CAUSE_RUN && over_cap)
            cause_close = evad_pkg::CAUSE_CAPACITY;
    end

    // Datapath next values
    always_comb
    begin
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        cap_next       = cap_reg;
        quiet_next     = quiet_reg;
        speech_next    = speech_reg;
        cause_next     = cause_reg;
        pstored_next   = pstored_reg;
        psample_next   = psample_reg;
        pdone_next     = pdone_reg;
        plevel_next    = plevel_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && res_stall;
        out_item_next  = out_item_reg;

        case (state_reg)
            evad_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    pstored_next = 1'b0;
                    psample_next = '0;
                    pdone_next   = 1'b0;
                    plevel_next  = '0;
                    case (req_item.req_type)
                        evad_pkg::REQ_RESTART:
                        begin
                            sum_next    = '0;
                            cnt_next    = '0;
                            cap_next    = '0;
                            quiet_next  = '0;
                            speech_next = 1'b0;
                            cause_next  = evad_pkg::CAUSE_RUN;
                        end
                        evad_pkg::REQ_SRC_END:
                        begin
                            if (cause_reg == evad_pkg::CAUSE_RUN)
                            begin
                                cause_next = evad_pkg::CAUSE_SRC_END;
                                sum_next   = '0;
                                cnt_next   = '0;
                            end
                        end
                        evad_pkg::REQ_SAMPLE:
                        begin
                            if (cause_reg == evad_pkg::CAUSE_RUN)
                            begin
                                if (cnt_reg == '0 && over_cap)
                                    cause_next = evad_pkg::CAUSE_CAPACITY;
                                else
                                begin
                                    pstored_next = 1'b1;
                                    psample_next = req_item.sample;
                                    cap_next     = cap_reg + evad_pkg::CAP_W'(1);
                                    if (close_now)
                                    begin
                                        // hand the frame to the divider
                                        pdone_next = 1'b1;
                                        sum_next   = '0;
                                        cnt_next   = '0;
                                        dvd_next   = sum_add;
                                        dvs_next   = cnt_add;
                                        rem_next   = '0;
                                        step_next  = '0;
                                    end
                                    else
                                    begin
                                        sum_next = sum_add;
                                        cnt_next = cnt_add;
                                    end
                                end
                            end
                        end
                        default:
                            pstored_next = 1'b0;
                    endcase
                end
            end
            evad_pkg::ST_DIV:
            begin
                // one quotient bit per cycle
                rem_next  = trial_ge ? evad_pkg::CNT_W'(trial - {1'b0, dvs_reg})
                                     : trial[evad_pkg::CNT_W-1:0];
                dvd_next  = {dvd_reg[evad_pkg::SUM_W-2:0], trial_ge};
                step_next = step_reg + evad_pkg::STEP_W'(1);
            end
            evad_pkg::ST_CLOSE:
            begin
                plevel_next = dvd_reg[evad_pkg::LVL_W-1:0];
                cause_next  = cause_close;
                if (dvd_reg[evad_pkg::LVL_W-1:0] > thr_reg)
                begin
                    speech_next = 1'b1;
                    quiet_next  = '0;
                end
                else if (speech_reg)
                    quiet_next = quiet_inc;
            end
            evad_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.stored        = pstored_reg;
                    out_item_next.stored_sample = psample_reg;
                    out_item_next.frame_done    = pdone_reg;
                    out_item_next.frame_level   = plevel_reg;
                    out_item_next.speech_seen   = speech_reg;
                    out_item_next.stopped       = cause_reg != evad_pkg::CAUSE_RUN;
                    out_item_next.stop_cause    = cause_reg;
                    out_item_next.total_samples = cap_reg;
                    out_item_next.too_short     = (cause_reg != evad_pkg::CAUSE_RUN)
                        && (cap_reg < {{(evad_pkg::CAP_W-evad_pkg::RATE_W+1){1'b0}},
                                       rate_reg[evad_pkg::RATE_W-1:1]});
                end
            end
            default:
                out_valid_next = out_valid_reg && res_stall;
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= evad_pkg::THR_RESET;
            sil_reg  <= evad_pkg::SIL_RESET;
            rate_reg <= evad_pkg::RATE_RESET;
            max_reg  <= evad_pkg::MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                evad_pkg::CFG_THRESHOLD: thr_reg  <= cfg_data[evad_pkg::THR_W-1:0];
                evad_pkg::CFG_SILENCE:   sil_reg  <= cfg_data[evad_pkg::SIL_W-1:0];
                evad_pkg::CFG_RATE:      rate_reg <= cfg_data[evad_pkg::RATE_W-1:0];
                evad_pkg::CFG_MAX:       max_reg  <= cfg_data[evad_pkg::CAP_W-1:0];
                default:                 thr_reg  <= thr_reg;
            endcase
        end
    end

    // Control and session state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= evad_pkg::ST_IDLE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            cap_reg       <= '0;
            quiet_reg     <= '0;
            speech_reg    <= 1'b0;
            cause_reg     <= evad_pkg::CAUSE_RUN;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            cap_reg       <= cap_next;
            quiet_reg     <= quiet_next;
            speech_reg    <= speech_next;
            cause_reg     <= cause_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pstored_reg  <= pstored_next;
        psample_reg  <= psample_next;
        pdone_reg    <= pdone_next;
        plevel_reg   <= plevel_next;
        dvd_reg      <= dvd_next;
        dvs_reg      <= dvs_next;
        rem_reg      <= rem_next;
        out_item_reg <= out_item_next;
    end

endmodule

// ===== hw/rtl/evad_chk.sv =====
// Port-level checker for the energy voice activity detector, bound to the core.
module evad_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_stall,
    input evad_pkg::req_t              req_item,
    input logic                        res_valid,
    input logic                        res_stall,
    input evad_pkg::res_t              res_item,
    input logic                        cfg_valid,
    input logic                        cfg_ready,
    input logic [1:0]                  cfg_index,
    input logic [evad_pkg::CFG_W-1:0]  cfg_data
);

    // A held result does not change
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("result changed while stalled");

    // One item at a time: the block is busy right after taking one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("item accepted while previous one in flight");

    // Stop flag agrees with the cause, and the short flag needs a stop
    a_stop_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.stopped == (res_item.stop_cause != evad_pkg::CAUSE_RUN))
                      && (!res_item.too_short || res_item.stopped))
        else $error("inconsistent stop status");

    // Pass-through and level are zero unless stored or frame closed
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.stored || res_item.stored_sample == '0)
                      && (res_item.frame_done || res_item.frame_level == '0))
        else $error("unused result field not zero");

endmodule

bind energy_voice_activity_detector_core evad_chk u_evad_chk (.*);
